### rtl/dtt_pkg.sv
// ----------------------------------------------------------------------------
// dtt_pkg
// Shared types and constants of the deadline timer table.
// ----------------------------------------------------------------------------
package dtt_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

  typedef enum logic [1:0] {
    OP_ARM_ONESHOT  = 2'd0,
    OP_ARM_PERIODIC = 2'd1,
    OP_CLEAR        = 2'd2,
    OP_TICK         = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    EV_ARM_ACK   = 2'd0,
    EV_CLEAR_ACK = 2'd1,
    EV_FIRED     = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] amount;
    logic [31:0] handle;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [31:0] timer_handle;
    logic [1:0]  status;
    logic        last;
  } evt_t;

  typedef struct packed {
    logic [31:0] handle;
    logic [63:0] deadline;
    logic [31:0] period;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

### rtl/deadline_timer_table.sv
// ----------------------------------------------------------------------------
// deadline_timer_table
// Table of one-shot and periodic timers against a running 64-bit time count.
// ----------------------------------------------------------------------------
// The timer entries (handle, deadline, period) live in one RAM with a single
// read port; live flags sit in flip-flops and are cleared by reset, so the
// block takes commands right after reset. Every command walks all slots of
// the RAM, one slot per cycle except while a fired result waits on a stalled
// event side: an arm looks for a live entry already holding the new handle
// and the lowest free slot, a clear looks for its handle, and a tick
// compares each live deadline with the advanced time and writes back
// periodic deadlines as it goes. Fired events leave in slot order, with
// last set on the final one; a tick with nothing due gives no event. Arm
// and clear each give one acknowledge beat.
// ----------------------------------------------------------------------------
module deadline_timer_table (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  dtt_pkg::cmd_t  cmd,
  output logic           evt_valid,
  input  logic           evt_stall,
  output dtt_pkg::evt_t  evt
);

  dtt_pkg::state_t state, state_next;
  dtt_pkg::op_t    op;
  logic [31:0]     amount_r;
  logic [31:0]     handle_r;
  logic [63:0]     time_now;
  logic [31:0]     next_handle;
  logic [dtt_pkg::TIMER_SLOTS-1:0] entry_valid;

  logic [dtt_pkg::CNT_W-1:0] rd_cnt;
  logic [dtt_pkg::IDX_W-1:0] ev_idx;
  logic                      match_found;
  logic [dtt_pkg::IDX_W-1:0] match_idx;
  logic                      free_found;
  logic [dtt_pkg::IDX_W-1:0] free_idx;
  logic                      hold_valid;
  logic [31:0]               hold_handle;

  logic                      ram_we;
  logic [dtt_pkg::IDX_W-1:0] ram_waddr;
  dtt_pkg::entry_t           ram_wdata;
  logic                      ram_re;
  logic [dtt_pkg::IDX_W-1:0] ram_raddr;
  logic [dtt_pkg::ENTRY_W-1:0] ram_rdata;
  dtt_pkg::entry_t           rd_entry;

  logic                      out_free;
  logic                      push;
  dtt_pkg::evt_t             push_evt;
  logic                      advance;
  logic                      fires;
  logic                      ev_live;
  logic [31:0]               key;
  logic                      arm_ok;
  logic [dtt_pkg::IDX_W-1:0] arm_slot;
  logic                      is_arm;

  assign rd_entry  = dtt_pkg::entry_t'(ram_rdata);
  assign out_free  = !evt_valid || !evt_stall;
  assign cmd_stall = (state != dtt_pkg::S_IDLE);
  assign ev_live   = entry_valid[ev_idx];
  assign key       = (op == dtt_pkg::OP_CLEAR) ? handle_r : next_handle;
  assign arm_ok    = match_found || free_found;
  assign arm_slot  = match_found ? match_idx : free_idx;
  assign is_arm    = (op == dtt_pkg::OP_ARM_ONESHOT) || (op == dtt_pkg::OP_ARM_PERIODIC);

  dtt_ram #(
    .WIDTH (dtt_pkg::ENTRY_W),
    .DEPTH (dtt_pkg::TIMER_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_re     = 1'b0;
    ram_raddr  = rd_cnt[dtt_pkg::IDX_W-1:0];
    ram_we     = 1'b0;
    ram_waddr  = ev_idx;
    ram_wdata  = rd_entry;
    push       = 1'b0;
    push_evt   = '0;
    advance    = 1'b0;
    fires      = 1'b0;
    case (state)
      dtt_pkg::S_IDLE: begin
        if (cmd_valid) begin
          ram_re     = 1'b1;
          ram_raddr  = '0;
          state_next = dtt_pkg::S_SCAN;
        end
      end
      dtt_pkg::S_SCAN: begin
        fires   = (op == dtt_pkg::OP_TICK) && ev_live && (rd_entry.deadline < time_now);
        advance = !(fires && hold_valid && !out_free);
        if (fires && hold_valid) begin
          push                  = advance;
          push_evt.event_kind   = dtt_pkg::EV_FIRED;
          push_evt.timer_handle = hold_handle;
          push_evt.status       = dtt_pkg::ST_OK;
          push_evt.last         = 1'b0;
        end
        if (advance) begin
          if (fires && (rd_entry.period != 32'd0)) begin
            ram_we             = 1'b1;
            ram_wdata.deadline = rd_entry.deadline + {32'd0, rd_entry.period};
          end
          if (rd_cnt == dtt_pkg::CNT_W'(dtt_pkg::TIMER_SLOTS)) begin
            state_next = dtt_pkg::S_FINISH;
          end else begin
            ram_re = 1'b1;
          end
        end
      end
      dtt_pkg::S_FINISH: begin
        push_evt.last = 1'b1;
        case (op)
          dtt_pkg::OP_TICK: begin
            push_evt.event_kind   = dtt_pkg::EV_FIRED;
            push_evt.timer_handle = hold_handle;
            push_evt.status       = dtt_pkg::ST_OK;
            push = hold_valid && out_free;
            if (!hold_valid || out_free) begin
              state_next = dtt_pkg::S_IDLE;
            end
          end
          dtt_pkg::OP_CLEAR: begin
            push_evt.event_kind   = dtt_pkg::EV_CLEAR_ACK;
            push_evt.timer_handle = handle_r;
            push_evt.status       = match_found ? dtt_pkg::ST_OK : dtt_pkg::ST_NOT_FOUND;
            push = out_free;
            if (out_free) begin
              state_next = dtt_pkg::S_IDLE;
            end
          end
          default: begin
            push_evt.event_kind   = dtt_pkg::EV_ARM_ACK;
            push_evt.timer_handle = arm_ok ? next_handle : 32'd0;
            push_evt.status       = arm_ok ? dtt_pkg::ST_OK : dtt_pkg::ST_FULL;
            push      = out_free;
            ram_we    = out_free && arm_ok;
            ram_waddr = arm_slot;
            ram_wdata.handle   = next_handle;
            ram_wdata.deadline = time_now + {32'd0, amount_r};
            ram_wdata.period   = (op == dtt_pkg::OP_ARM_PERIODIC) ? amount_r : 32'd0;
            if (out_free) begin
              state_next = dtt_pkg::S_IDLE;
            end
          end
        endcase
      end
      default: begin
        state_next = dtt_pkg::S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      time_now    <= '0;
      next_handle <= '0;
      entry_valid <= '0;
      rd_cnt      <= '0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      hold_valid  <= 1'b0;
      evt_valid   <= 1'b0;
    end else begin
      if (push) begin
        evt_valid <= 1'b1;
      end else if (!evt_stall) begin
        evt_valid <= 1'b0;
      end
      case (state)
        dtt_pkg::S_IDLE: begin
          if (cmd_valid) begin
            if (dtt_pkg::op_t'(cmd.opcode) == dtt_pkg::OP_TICK) begin
              time_now <= time_now + {32'd0, cmd.amount};
            end
            rd_cnt      <= dtt_pkg::CNT_W'(1);
            match_found <= 1'b0;
            free_found  <= 1'b0;
            hold_valid  <= 1'b0;
          end
        end
        dtt_pkg::S_SCAN: begin
          if (advance) begin
            if (ram_re) begin
              rd_cnt <= rd_cnt + dtt_pkg::CNT_W'(1);
            end
            if ((op != dtt_pkg::OP_TICK) && ev_live && (rd_entry.handle == key)
                && !match_found) begin
              match_found <= 1'b1;
            end
            if (!ev_live && !free_found) begin
              free_found <= 1'b1;
            end
            if (fires) begin
              hold_valid <= 1'b1;
              if (rd_entry.period == 32'd0) begin
                entry_valid[ev_idx] <= 1'b0;
              end
            end
          end
        end
        dtt_pkg::S_FINISH: begin
          if (out_free) begin
            if (is_arm && arm_ok) begin
              entry_valid[arm_slot] <= 1'b1;
              next_handle           <= next_handle + 32'd1;
            end
            if ((op == dtt_pkg::OP_CLEAR) && match_found) begin
              entry_valid[match_idx] <= 1'b0;
            end
          end
          if (state_next == dtt_pkg::S_IDLE) begin
            hold_valid <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (push) begin
      evt <= push_evt;
    end
    if ((state == dtt_pkg::S_IDLE) && cmd_valid) begin
      op       <= dtt_pkg::op_t'(cmd.opcode);
      amount_r <= cmd.amount;
      handle_r <= cmd.handle;
      ev_idx   <= '0;
    end
    if ((state == dtt_pkg::S_SCAN) && advance) begin
      if (ram_re) begin
        ev_idx <= rd_cnt[dtt_pkg::IDX_W-1:0];
      end
      if ((op != dtt_pkg::OP_TICK) && ev_live && (rd_entry.handle == key) && !match_found) begin
        match_idx <= ev_idx;
      end
      if (!ev_live && !free_found) begin
        free_idx <= ev_idx;
      end
      if (fires) begin
        hold_handle <= rd_entry.handle;
      end
    end
  end

  a_fired_ok: assert property (@(posedge clk) disable iff (rst)
    evt_valid && (evt.event_kind == dtt_pkg::EV_FIRED) |-> evt.status == dtt_pkg::ST_OK)
    else $error("fired beat with nonzero status");

  a_ack_last: assert property (@(posedge clk) disable iff (rst)
    evt_valid && (evt.event_kind != dtt_pkg::EV_FIRED) |-> evt.last)
    else $error("acknowledge beat without last");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == dtt_pkg::S_SCAN) |-> (rd_cnt <= dtt_pkg::CNT_W'(dtt_pkg::TIMER_SLOTS))
                                   && (rd_cnt != '0))
    else $error("scan counter out of range");

  a_idle_no_hold: assert property (@(posedge clk) disable iff (rst)
    (state == dtt_pkg::S_IDLE) |-> !hold_valid)
    else $error("pending fired beat left behind");

  a_full_real: assert property (@(posedge clk) disable iff (rst)
    (state == dtt_pkg::S_FINISH) && push && is_arm && !arm_ok |-> &entry_valid)
    else $error("table full reported with a free slot");

  a_handle_step: assert property (@(posedge clk) disable iff (rst)
    (state == dtt_pkg::S_SCAN) |=> $stable(next_handle))
    else $error("handle counter moved during scan");

endmodule

### rtl/dtt_ram.sv
// ----------------------------------------------------------------------------
// dtt_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module dtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### bench/tb_deadline_timer_table.sv
// ----------------------------------------------------------------------------
// tb_deadline_timer_table
// Self-checking bench for the deadline timer table.
// ----------------------------------------------------------------------------
// A short directed script runs first. It covers a clear on an empty table,
// arms at the extreme delays, a zero period, a full table and a tick that
// fires every slot at once. A random mix of arms, clears of live and unknown
// handles, and ticks follows. A bench-side timer table predicts every event
// beat. Events are checked in order against the oldest pending prediction.
// Both channels idle at random. There is a calm stretch with no idling, a
// long receive hold-off that backs the block up, and one drain pause.
// ----------------------------------------------------------------------------
module tb_deadline_timer_table;

  localparam int RANDOM_ITEMS   = 140;
  localparam int HOLD_CYCLES    = 300;
  localparam int CMD_CYCLES     = dtt_pkg::TIMER_SLOTS + 2;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    dtt_pkg::cmd_t c;
    int            reps;
    bit            typed;
    dtt_pkg::evt_t ev;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  dtt_pkg::cmd_t cmd = '0;
  logic evt_valid;
  logic evt_stall = 1'b0;
  dtt_pkg::evt_t evt;

  logic calm = 1'b0;
  logic hold_req = 1'b0;
  bit   hold_served = 1'b0;
  int   error_count = 0;
  int   quiet_cycles = 0;

  // bench-side timer table
  logic [63:0] clock_ns = '0;
  logic [31:0] handle_ctr = '0;
  bit          slot_live [dtt_pkg::TIMER_SLOTS];
  logic [31:0] slot_handle [dtt_pkg::TIMER_SLOTS];
  logic [63:0] slot_due [dtt_pkg::TIMER_SLOTS];
  logic [31:0] slot_period [dtt_pkg::TIMER_SLOTS];

  dtt_pkg::evt_t pending_events [$];
  row_t script [$];

  deadline_timer_table DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic enqueue_event(input dtt_pkg::evt_t e);
    pending_events.insert(pending_events.size(), e);
  endtask

  task automatic add_row(input row_t r);
    script.insert(script.size(), r);
  endtask

  function automatic int live_slot(logic [31:0] h);
    int i;
    live_slot = -1;
    for (i = dtt_pkg::TIMER_SLOTS - 1; i >= 0; i--) begin
      if (slot_live[i] && slot_handle[i] == h) live_slot = i;
    end
  endfunction

  task automatic predict_events(input dtt_pkg::cmd_t c);
    int            slot;
    int            i;
    bit            have_prev;
    dtt_pkg::evt_t e;
    dtt_pkg::evt_t prev;
    e = '0;
    prev = '0;
    have_prev = 1'b0;
    case (c.opcode)
      dtt_pkg::OP_ARM_ONESHOT, dtt_pkg::OP_ARM_PERIODIC: begin
        e.event_kind = dtt_pkg::EV_ARM_ACK;
        e.last = 1'b1;
        slot = live_slot(handle_ctr);
        if (slot < 0) begin
          for (i = dtt_pkg::TIMER_SLOTS - 1; i >= 0; i--) begin
            if (!slot_live[i]) slot = i;
          end
        end
        if (slot < 0) begin
          e.status = dtt_pkg::ST_FULL;
        end else begin
          slot_live[slot] = 1'b1;
          slot_handle[slot] = handle_ctr;
          slot_due[slot] = clock_ns + {32'd0, c.amount};
          slot_period[slot] = (c.opcode == dtt_pkg::OP_ARM_PERIODIC) ? c.amount : 32'd0;
          e.timer_handle = handle_ctr;
          handle_ctr = handle_ctr + 32'd1;
        end
        enqueue_event(e);
      end
      dtt_pkg::OP_CLEAR: begin
        e.event_kind = dtt_pkg::EV_CLEAR_ACK;
        e.timer_handle = c.handle;
        e.last = 1'b1;
        slot = live_slot(c.handle);
        if (slot < 0) e.status = dtt_pkg::ST_NOT_FOUND;
        else slot_live[slot] = 1'b0;
        enqueue_event(e);
      end
      default: begin
        clock_ns = clock_ns + {32'd0, c.amount};
        e.event_kind = dtt_pkg::EV_FIRED;
        for (i = 0; i < dtt_pkg::TIMER_SLOTS; i++) begin
          if (slot_live[i] && slot_due[i] < clock_ns) begin
            if (have_prev) enqueue_event(prev);
            e.timer_handle = slot_handle[i];
            prev = e;
            have_prev = 1'b1;
            if (slot_period[i] == 32'd0) slot_live[i] = 1'b0;
            else slot_due[i] = slot_due[i] + {32'd0, slot_period[i]};
          end
        end
        if (have_prev) begin
          prev.last = 1'b1;
          enqueue_event(prev);
        end
      end
    endcase
  endtask

  function automatic logic [31:0] pick_amount();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) pick_amount = $urandom_range(0, 60);
    else if (r < 85) pick_amount = $urandom_range(0, 2000);
    else pick_amount = $urandom();
  endfunction

  function automatic dtt_pkg::cmd_t random_cmd();
    dtt_pkg::cmd_t c;
    int            r;
    int            s;
    c.handle = $urandom();
    c.amount = pick_amount();
    r = $urandom_range(0, 99);
    if (r < 34) begin
      c.opcode = dtt_pkg::OP_ARM_ONESHOT;
    end else if (r < 52) begin
      c.opcode = dtt_pkg::OP_ARM_PERIODIC;
      if ($urandom_range(0, 9) == 0) c.amount = '0;
    end else if (r < 74) begin
      c.opcode = dtt_pkg::OP_CLEAR;
      s = $urandom_range(0, dtt_pkg::TIMER_SLOTS - 1);
      if (slot_live[s] && $urandom_range(0, 3) != 0) c.handle = slot_handle[s];
      else if ($urandom_range(0, 1) == 0) c.handle = handle_ctr - $urandom_range(1, 8);
    end else begin
      c.opcode = dtt_pkg::OP_TICK;
    end
    random_cmd = c;
  endfunction

  function automatic row_t step_row(dtt_pkg::op_t op, logic [31:0] amt, logic [31:0] hnd,
                                    int reps, bit typed, dtt_pkg::kind_t k,
                                    logic [31:0] eh, dtt_pkg::status_t st);
    row_t r;
    r.c.opcode = op;
    r.c.amount = amt;
    r.c.handle = hnd;
    r.reps = reps;
    r.typed = typed;
    r.ev.event_kind = k;
    r.ev.timer_handle = eh;
    r.ev.status = st;
    r.ev.last = 1'b1;
    step_row = r;
  endfunction

  task automatic send(input dtt_pkg::cmd_t c, input bit typed, input dtt_pkg::evt_t ev);
    int gap;
    int base;
    if (!calm && $urandom_range(0, 99) < 32) begin
      gap = $urandom_range(1, 24);
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    base = pending_events.size();
    predict_events(c);
    if (typed) begin
      while (pending_events.size() > base) void'(pending_events.pop_back());
      enqueue_event(ev);
    end
  endtask

  // receive side
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        evt_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        evt_stall <= 1'b0;
      end else begin
        evt_stall <= !calm && ($urandom_range(0, 99) < 32);
      end
    end
  end

  // event beat checker
  always @(posedge clk) begin : check_evt
    dtt_pkg::evt_t want;
    if (!rst && evt_valid && !evt_stall) begin
      if (pending_events.size() == 0) begin
        if (error_count < 10)
          $display("unexpected beat: kind %0d handle %h status %0d last %0d",
                   evt.event_kind, evt.timer_handle, evt.status, evt.last);
        error_count++;
      end else begin
        want = pending_events.pop_front();
        if (evt.event_kind !== want.event_kind || evt.timer_handle !== want.timer_handle ||
            evt.status !== want.status || evt.last !== want.last) begin
          if (error_count < 10)
            $display("mismatch: kind %0d/%0d handle %h/%h status %0d/%0d last %0d/%0d",
                     want.event_kind, evt.event_kind, want.timer_handle, evt.timer_handle,
                     want.status, evt.status, want.last, evt.last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (evt_valid && !evt_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_deadline_timer_table: errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int            r;
    int            k;
    int            n;
    dtt_pkg::evt_t none;
    none = '0;
    for (k = 0; k < dtt_pkg::TIMER_SLOTS; k++) slot_live[k] = 1'b0;

    add_row(step_row(dtt_pkg::OP_CLEAR, 32'd0, 32'd0, 1, 1'b1, dtt_pkg::EV_CLEAR_ACK,
                     32'd0, dtt_pkg::ST_NOT_FOUND));
    add_row(step_row(dtt_pkg::OP_ARM_ONESHOT, 32'd0, 32'hFFFF_FFFF, 1, 1'b1,
                     dtt_pkg::EV_ARM_ACK, 32'd0, dtt_pkg::ST_OK));
    add_row(step_row(dtt_pkg::OP_TICK, 32'd0, 32'd0, 1, 1'b0, dtt_pkg::EV_FIRED, 32'd0,
                     dtt_pkg::ST_OK));
    add_row(step_row(dtt_pkg::OP_TICK, 32'd1, 32'd0, 1, 1'b0, dtt_pkg::EV_FIRED, 32'd0,
                     dtt_pkg::ST_OK));
    add_row(step_row(dtt_pkg::OP_ARM_PERIODIC, 32'hFFFF_FFFF, 32'd0, 1, 1'b1,
                     dtt_pkg::EV_ARM_ACK, 32'd1, dtt_pkg::ST_OK));
    add_row(step_row(dtt_pkg::OP_ARM_PERIODIC, 32'd1, 32'd0, 1, 1'b1,
                     dtt_pkg::EV_ARM_ACK, 32'd2, dtt_pkg::ST_OK));
    // zero period behaves as one-shot
    add_row(step_row(dtt_pkg::OP_ARM_PERIODIC, 32'd0, 32'd0, 1, 1'b1,
                     dtt_pkg::EV_ARM_ACK, 32'd3, dtt_pkg::ST_OK));
    add_row(step_row(dtt_pkg::OP_TICK, 32'd3, 32'hFFFF_FFFF, 1, 1'b0, dtt_pkg::EV_FIRED,
                     32'd0, dtt_pkg::ST_OK));
    add_row(step_row(dtt_pkg::OP_CLEAR, 32'hFFFF_FFFF, 32'd1, 1, 1'b1,
                     dtt_pkg::EV_CLEAR_ACK, 32'd1, dtt_pkg::ST_OK));
    add_row(step_row(dtt_pkg::OP_CLEAR, 32'd0, 32'd1, 1, 1'b1, dtt_pkg::EV_CLEAR_ACK,
                     32'd1, dtt_pkg::ST_NOT_FOUND));
    add_row(step_row(dtt_pkg::OP_CLEAR, 32'd0, 32'hFFFF_FFFF, 1, 1'b1,
                     dtt_pkg::EV_CLEAR_ACK, 32'hFFFF_FFFF, dtt_pkg::ST_NOT_FOUND));
    // fill the table, then arm once more
    add_row(step_row(dtt_pkg::OP_ARM_ONESHOT, 32'd1000, 32'd0, dtt_pkg::TIMER_SLOTS - 1,
                     1'b0, dtt_pkg::EV_ARM_ACK, 32'd0, dtt_pkg::ST_OK));
    add_row(step_row(dtt_pkg::OP_ARM_ONESHOT, 32'd5, 32'd0, 1, 1'b1, dtt_pkg::EV_ARM_ACK,
                     32'd0, dtt_pkg::ST_FULL));
    // every slot fires on one tick
    add_row(step_row(dtt_pkg::OP_TICK, 32'hFFFF_FFFF, 32'd0, 1, 1'b0, dtt_pkg::EV_FIRED,
                     32'd0, dtt_pkg::ST_OK));
    add_row(step_row(dtt_pkg::OP_CLEAR, 32'd0, 32'd2, 1, 1'b1, dtt_pkg::EV_CLEAR_ACK,
                     32'd2, dtt_pkg::ST_OK));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (r = 0; r < script.size(); r++) begin
      for (k = 0; k < script[r].reps; k++) send(script[r].c, script[r].typed, script[r].ev);
    end

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 30) hold_req <= 1'b1;
      if (n == 70) begin
        cmd_valid <= 1'b0;
        do @(posedge clk); while (pending_events.size() != 0);
      end
      calm <= (n >= 90 && n < 120);
      send(random_cmd(), 1'b0, none);
    end

    cmd_valid <= 1'b0;
    do @(posedge clk); while (pending_events.size() != 0);
    repeat (2 * CMD_CYCLES) @(posedge clk);
    if (pending_events.size() != 0) error_count++;

    if (error_count == 0) begin
      $display("tb_deadline_timer_table: clean");
    end else begin
      $display("tb_deadline_timer_table: errors");
    end
    $finish;
  end

endmodule
